/* rtl/core/chc_pkg.sv */
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types and codes for the canonical huffman codec: request and
// response payloads, item kinds, result kinds, sequencer states, unit ops.
// ----------------------------------------------------------------------------
package chc_pkg;

	localparam int BYTE_BITS = 8;

	typedef enum logic [2:0] {
		K_LOAD  = 3'd0,
		K_BUILD = 3'd1,
		K_ENC   = 3'd2,
		K_FLUSH = 3'd3,
		K_START = 3'd4,
		K_DEC   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		OK_BYTE = 2'd0,
		OK_SYM  = 2'd1,
		OK_ERR  = 2'd2
	} out_kind_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_BSCAN,
		S_BDRAIN,
		S_ELOAD,
		S_EBIT,
		S_FLUSH,
		S_DBIT,
		S_DCMP,
		S_DIDX,
		S_DSYM,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		ALU_NEXT,
		ALU_OFFS,
		ALU_LAST
	} alu_op_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  symbol;
		logic [4:0]  code_length;
		logic [7:0]  data_byte;
		logic [15:0] symbol_budget;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic [7:0] out_symbol;
		logic       last;
	} rsp_t;

endpackage

/* rtl/core/canonical_huffman_codec_top.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_codec_top
// Canonical huffman codec: length load, code build, encode, flush, decode.
// ----------------------------------------------------------------------------
// One item at a time; req_stall is high while an item is in work. After reset
// a clearing pass zeroes the length table. Load and start decode are done on
// acceptance. A build walks every length and symbol through the length table
// read port. Encode sends one bit per cycle through the packer, except while a
// full packed byte waits for the result buffer. Decode takes for each bit a bit
// step and an offset compare, and on a match a last-index step and a sorted-
// symbol read; the compare and the last-index step use the shared unit.
// Results stall the sequencer only when pending result and output are both full.
module canonical_huffman_codec_top #(
	parameter int ALPHABET_SIZE   = 256,
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  chc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output chc_pkg::rsp_t rsp
);

	localparam int SW  = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int CW  = SW + 1;
	localparam int LW  = $clog2(MAX_CODE_LENGTH + 1);
	localparam int PLW = $clog2(MAX_CODE_LENGTH + 2);
	localparam int MW  = MAX_CODE_LENGTH;
	localparam int KW  = MW + SW + 2;
	localparam int NL  = MAX_CODE_LENGTH + 1;

	chc_pkg::state_t state_q, state_d;

	// memories
	logic [LW-1:0]    len_mem [ALPHABET_SIZE];
	logic [LW+MW-1:0] code_mem [ALPHABET_SIZE];
	logic [SW-1:0]    sort_mem [ALPHABET_SIZE];
	logic [LW-1:0]    len_rd_q;
	logic [LW+MW-1:0] code_rd_q;
	logic [SW-1:0]    sort_rd_q;
	logic [SW-1:0]    sort_addr;

	// per-length tables
	logic [CW-1:0] cnt_tab_q [NL];
	logic [MW-1:0] first_tab_q [NL];
	logic [SW-1:0] off_tab_q [NL];
	logic [LW-1:0] tl_idx;
	logic [CW-1:0] cnt_rd;
	logic [MW-1:0] first_rd;
	logic [SW-1:0] off_rd;

	// sequencer and datapath
	logic [SW-1:0]  s_q;
	logic [LW-1:0]  len_q;
	logic           vld_s1;
	logic [SW-1:0]  s_s1;
	logic [LW-1:0]  len_s1;
	logic [CW-1:0]  sorted_cnt_q;
	logic [MW-1:0]  bcode_q;
	logic [LW-1:0]  cur_q;
	logic           built_q;
	logic [7:0]     pack_q;
	logic [2:0]     pcnt_q;
	logic [LW-1:0]  ebits_q;
	logic [MW-1:0]  ecode_q;
	logic [MW-1:0]  p_q;
	logic [PLW-1:0] plen_q;
	logic [15:0]    left_q;
	logic [7:0]     byte_q;
	logic [3:0]     bi_q;
	logic [KW-1:0]  k_q;

	logic           accept;
	logic           sym_ok;
	logic [SW-1:0]  sym_idx;
	logic [LW-1:0]  clen_sat;
	logic           s_last;
	logic           len_last;
	logic           b_match;
	logic [MW-1:0]  b_code;
	logic           e_bit;
	logic [MW-1:0]  e_shift;
	logic [7:0]     e_byte;
	logic           d_hit;
	logic           d_over;
	logic           d_shift;

	chc_pkg::alu_op_t alu_op;
	logic [KW-1:0]    alu_a, alu_b, alu_c, alu_y;
	logic [LW-1:0]    alu_la, alu_lb;
	logic             alu_lt;

	logic          emit, fin, out_rdy;
	chc_pkg::rsp_t res;

	assign req_stall = (state_q != chc_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign sym_ok    = (32'(req.symbol) < ALPHABET_SIZE);
	assign sym_idx   = SW'(req.symbol);
	assign clen_sat  = (32'(req.code_length) > MAX_CODE_LENGTH) ?
		LW'(MAX_CODE_LENGTH) : LW'(req.code_length);
	assign s_last    = (32'(s_q) == ALPHABET_SIZE - 1);
	assign len_last  = (32'(len_q) == MAX_CODE_LENGTH);

	// table read port is shared between build and decode
	assign tl_idx   = (state_q == chc_pkg::S_DCMP || state_q == chc_pkg::S_DIDX) ?
		plen_q[LW-1:0] : len_s1;
	assign cnt_rd   = cnt_tab_q[tl_idx];
	assign first_rd = first_tab_q[tl_idx];
	assign off_rd   = off_tab_q[tl_idx];

	chc_alu #(.KW(KW), .LW(LW)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.c  (alu_c),
		.la (alu_la),
		.lb (alu_lb),
		.y  (alu_y),
		.lt (alu_lt)
	);

	always_comb begin
		alu_op = chc_pkg::ALU_NEXT;
		alu_a  = KW'(bcode_q);
		alu_b  = '0;
		alu_c  = KW'(cnt_rd);
		alu_la = cur_q;
		alu_lb = len_s1;
		if (state_q == chc_pkg::S_DCMP) begin
			alu_op = chc_pkg::ALU_OFFS;
			alu_a  = KW'(p_q);
			alu_b  = KW'(first_rd);
			alu_la = plen_q[LW-1:0];
		end else if (state_q == chc_pkg::S_DIDX) begin
			alu_op = chc_pkg::ALU_LAST;
			alu_a  = k_q;
			alu_la = plen_q[LW-1:0];
		end
	end

	assign b_match   = vld_s1 && (len_rd_q == len_s1);
	assign b_code    = (sorted_cnt_q == '0) ? '0 : alu_y[MW-1:0];
	assign e_shift   = ecode_q >> LW'(ebits_q - LW'(1));
	assign e_bit     = e_shift[0];
	assign e_byte    = pack_q | (e_bit ? (8'h80 >> pcnt_q) : 8'h00);
	assign d_over    = (32'(plen_q) > MAX_CODE_LENGTH);
	assign d_hit     = built_q && !d_over && alu_lt;
	assign sort_addr = SW'(KW'(off_rd) + alu_y);
	// one new prefix bit per pass through the bit state
	assign d_shift   = (state_q == chc_pkg::S_DBIT) && (state_d == chc_pkg::S_DCMP);

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		fin     = 1'b0;
		res     = '0;
		unique case (state_q)
			chc_pkg::S_CLR: begin
				if (s_last) state_d = chc_pkg::S_IDLE;
			end
			chc_pkg::S_IDLE: begin
				if (accept) begin
					case (req.kind)
						chc_pkg::K_BUILD: state_d = chc_pkg::S_BSCAN;
						chc_pkg::K_ENC:   state_d = sym_ok ? chc_pkg::S_ELOAD : chc_pkg::S_IDLE;
						chc_pkg::K_FLUSH: state_d = chc_pkg::S_FLUSH;
						chc_pkg::K_DEC:   state_d = chc_pkg::S_DBIT;
						default:          state_d = chc_pkg::S_IDLE;
					endcase
				end
			end
			chc_pkg::S_BSCAN: begin
				if (s_last && len_last) state_d = chc_pkg::S_BDRAIN;
			end
			chc_pkg::S_BDRAIN: state_d = chc_pkg::S_DONE;
			chc_pkg::S_ELOAD:  state_d = chc_pkg::S_EBIT;
			chc_pkg::S_EBIT: begin
				if (ebits_q == '0) begin
					state_d = chc_pkg::S_DONE;
				end else if (pcnt_q == 3'd7) begin
					emit         = out_rdy;
					res.out_kind = chc_pkg::OK_BYTE;
					res.out_byte = e_byte;
				end
			end
			chc_pkg::S_FLUSH: begin
				if (pcnt_q == '0) begin
					state_d = chc_pkg::S_DONE;
				end else if (out_rdy) begin
					emit         = 1'b1;
					res.out_kind = chc_pkg::OK_BYTE;
					res.out_byte = pack_q;
					state_d      = chc_pkg::S_DONE;
				end
			end
			chc_pkg::S_DBIT: begin
				if (bi_q == 4'(chc_pkg::BYTE_BITS) || left_q == '0) begin
					state_d = chc_pkg::S_DONE;
				end else begin
					state_d = chc_pkg::S_DCMP;
				end
			end
			chc_pkg::S_DCMP: begin
				if (d_hit) begin
					state_d = chc_pkg::S_DIDX;
				end else if (d_over) begin
					if (out_rdy) begin
						emit         = 1'b1;
						res.out_kind = chc_pkg::OK_ERR;
						state_d      = chc_pkg::S_DBIT;
					end
				end else begin
					state_d = chc_pkg::S_DBIT;
				end
			end
			chc_pkg::S_DIDX: state_d = chc_pkg::S_DSYM;
			chc_pkg::S_DSYM: begin
				if (out_rdy) begin
					emit           = 1'b1;
					res.out_kind   = chc_pkg::OK_SYM;
					res.out_symbol = 8'(sort_rd_q);
					state_d        = chc_pkg::S_DBIT;
				end
			end
			chc_pkg::S_DONE: begin
				fin = 1'b1;
				if (out_rdy) state_d = chc_pkg::S_IDLE;
			end
			default: state_d = chc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chc_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q          <= '0;
			len_q        <= '0;
			vld_s1       <= 1'b0;
			sorted_cnt_q <= '0;
			built_q      <= 1'b0;
			pack_q       <= '0;
			pcnt_q       <= '0;
			p_q          <= '0;
			plen_q       <= '0;
			left_q       <= '0;
		end else begin
			vld_s1 <= (state_q == chc_pkg::S_BSCAN);
			if (state_q == chc_pkg::S_CLR) begin
				s_q <= s_last ? '0 : s_q + SW'(1);
			end
			if (accept && req.kind == chc_pkg::K_BUILD) begin
				s_q          <= '0;
				len_q        <= LW'(1);
				sorted_cnt_q <= '0;
			end
			if (accept && req.kind == chc_pkg::K_START) begin
				left_q <= req.symbol_budget;
				p_q    <= '0;
				plen_q <= '0;
			end
			if (state_q == chc_pkg::S_BSCAN) begin
				if (s_last) begin
					s_q   <= '0;
					len_q <= len_q + LW'(1);
				end else begin
					s_q <= s_q + SW'(1);
				end
			end
			if (b_match) sorted_cnt_q <= sorted_cnt_q + CW'(1);
			if (state_q == chc_pkg::S_BDRAIN) built_q <= 1'b1;
			// packer
			if (state_q == chc_pkg::S_EBIT && ebits_q != '0) begin
				if (pcnt_q != 3'd7) begin
					pack_q <= e_byte;
					pcnt_q <= pcnt_q + 3'd1;
				end else if (out_rdy) begin
					pack_q <= '0;
					pcnt_q <= '0;
				end
			end
			if (state_q == chc_pkg::S_FLUSH && pcnt_q != '0 && out_rdy) begin
				pack_q <= '0;
				pcnt_q <= '0;
			end
			// decode prefix
			if (d_shift) begin
				p_q    <= {p_q[MW-2:0], byte_q[7]};
				plen_q <= plen_q + PLW'(1);
			end
			if ((state_q == chc_pkg::S_DCMP && !d_hit && d_over && out_rdy) ||
				(state_q == chc_pkg::S_DSYM && out_rdy)) begin
				p_q    <= '0;
				plen_q <= '0;
			end
			if (state_q == chc_pkg::S_DSYM && out_rdy) left_q <= left_q - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		s_s1   <= s_q;
		len_s1 <= len_q;
		if (accept && req.kind == chc_pkg::K_DEC) begin
			byte_q <= req.data_byte;
			bi_q   <= '0;
		end
		if (d_shift) begin
			byte_q <= {byte_q[6:0], 1'b0};
			bi_q   <= bi_q + 4'd1;
		end
		if (state_q == chc_pkg::S_DCMP) k_q <= alu_y;
		if (state_q == chc_pkg::S_ELOAD) begin
			ebits_q <= built_q ? code_rd_q[LW+MW-1:MW] : '0;
			ecode_q <= code_rd_q[MW-1:0];
		end
		if (state_q == chc_pkg::S_EBIT && ebits_q != '0 &&
			(pcnt_q != 3'd7 || out_rdy)) begin
			ebits_q <= ebits_q - LW'(1);
		end
		// build stage one: place a symbol whose length matches this pass
		if (b_match) begin
			bcode_q <= b_code;
			cur_q   <= len_s1;
		end
		if (vld_s1) begin
			if (s_s1 == '0) begin
				cnt_tab_q[len_s1] <= b_match ? CW'(1) : '0;
			end else if (b_match) begin
				cnt_tab_q[len_s1] <= cnt_rd + CW'(1);
			end
			if (b_match && (s_s1 == '0 || cnt_rd == '0)) begin
				first_tab_q[len_s1] <= b_code;
				off_tab_q[len_s1]   <= sorted_cnt_q[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == chc_pkg::S_CLR) begin
			len_mem[s_q] <= '0;
		end else if (accept && req.kind == chc_pkg::K_LOAD && sym_ok) begin
			len_mem[sym_idx] <= clen_sat;
		end
		len_rd_q <= len_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (b_match) begin
			code_mem[s_s1] <= {len_s1, b_code};
		end else if (vld_s1 && len_s1 == LW'(1)) begin
			code_mem[s_s1] <= '0;
		end
		code_rd_q <= code_mem[sym_idx];
	end

	// sorted symbol is held while the result waits for the buffer
	always_ff @(posedge clk) begin
		if (b_match) sort_mem[sorted_cnt_q[SW-1:0]] <= s_s1;
		if (state_q == chc_pkg::S_DIDX) sort_rd_q <= sort_mem[sort_addr];
	end

	chc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.fin       (fin),
		.res       (res),
		.rdy       (out_rdy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_emit_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_rdy) else $error("result produced into full buffer");
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		32'(plen_q) <= MAX_CODE_LENGTH + 1) else $error("prefix too long");
	a_s1_src: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q) == chc_pkg::S_BSCAN) else $error("stray build stage");

endmodule

/* rtl/core/chc_alu.sv */
// ----------------------------------------------------------------------------
// chc_alu
// Shared add, mask, shift and compare unit used by code build and decode.
// ----------------------------------------------------------------------------
module chc_alu #(
	parameter int KW = 26,
	parameter int LW = 5
) (
	input  chc_pkg::alu_op_t op,
	input  logic [KW-1:0]    a,
	input  logic [KW-1:0]    b,
	input  logic [KW-1:0]    c,
	input  logic [LW-1:0]    la,
	input  logic [LW-1:0]    lb,
	output logic [KW-1:0]    y,
	output logic             lt
);

	logic [KW-1:0] mask;

	always_comb begin
		mask = (KW'(1) << la) - KW'(1);
		unique case (op)
			chc_pkg::ALU_NEXT: y = ((a + KW'(1)) & mask) << (lb - la);
			// offset of a prefix within the codes of one length
			chc_pkg::ALU_OFFS: y = (a - b) & mask;
			// last index with the same low bits below the count
			chc_pkg::ALU_LAST: y = a + ((c - KW'(1) - a) & ~mask);
			default:           y = '0;
		endcase
		lt = (y < c);
	end

endmodule

/* rtl/core/chc_out.sv */
// ----------------------------------------------------------------------------
// chc_out
// Result buffer: one pending result plus the output register, so the final
// result of an item can be marked last when the item ends.
// ----------------------------------------------------------------------------
module chc_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           emit,
	input  logic           fin,
	input  chc_pkg::rsp_t  res,
	output logic           rdy,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output chc_pkg::rsp_t  rsp
);

	logic          pend_v_q;
	chc_pkg::rsp_t pend_q;
	logic          out_free;

	assign out_free = !rsp_valid || !rsp_stall;
	assign rdy      = !pend_v_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (emit && rdy) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					rsp_valid <= 1'b1;
				end else if (out_free) begin
					rsp_valid <= 1'b0;
				end
			end else if (fin && rdy && pend_v_q) begin
				pend_v_q  <= 1'b0;
				rsp_valid <= 1'b1;
			end else if (out_free) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && rdy) begin
			pend_q <= chc_pkg::rsp_t'({res.out_kind, res.out_byte, res.out_symbol, 1'b0});
			if (pend_v_q) begin
				rsp <= chc_pkg::rsp_t'({pend_q.out_kind, pend_q.out_byte,
					pend_q.out_symbol, 1'b0});
			end
		end else if (fin && rdy && pend_v_q) begin
			rsp <= chc_pkg::rsp_t'({pend_q.out_kind, pend_q.out_byte,
				pend_q.out_symbol, 1'b1});
		end
	end

	a_no_emit_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && fin)) else $error("emit and fin together");
	a_last_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && rdy && pend_v_q) |=> (rsp_valid && rsp.last))
		else $error("final transfer not marked last");
	a_pend_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !emit && !fin) |=> pend_v_q) else $error("pending result lost");

endmodule

/* dv/canonical_huffman_codec_checker.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_codec_checker
// Watches both channels of the codec, keeps its own copy of the length table,
// the built codes, the bit packer and the decoder, predicts the results of
// every request transfer and compares each response transfer field by field.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  chc_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  chc_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);

	localparam int NSYM   = 256;
	localparam int MAXLEN = 16;

	logic [4:0]  len_tab [NSYM];
	logic [15:0] code_tab [NSYM];
	logic [4:0]  code_len [NSYM];
	logic [7:0]  canon_order [NSYM];
	int          canon_count;
	logic [7:0]  pack_byte;
	int          pack_bits;
	logic [31:0] prefix_code;
	int          prefix_len;
	logic [15:0] budget_left;

	chc_pkg::rsp_t codec_results_q [$];

	initial begin
		for (int s = 0; s < NSYM; s++) begin
			len_tab[s] = '0;
			code_tab[s] = '0;
			code_len[s] = '0;
			canon_order[s] = '0;
		end
		canon_count = 0;
		pack_byte = '0;
		pack_bits = 0;
		prefix_code = '0;
		prefix_len = 0;
		budget_left = '0;
		errors = 0;
		pending = 0;
	end

	function automatic chc_pkg::rsp_t mk_rsp(chc_pkg::out_kind_t k, logic [7:0] b,
	                                         logic [7:0] s);
		chc_pkg::rsp_t r;
		r.out_kind = k;
		r.out_byte = b;
		r.out_symbol = s;
		r.last = 1'b0;
		return r;
	endfunction

	// canonical order: by length, then by symbol; code wraps in its current width
	task automatic build_canonical();
		logic [31:0] code;
		int cur;
		code = '0;
		cur = 0;
		canon_count = 0;
		for (int s = 0; s < NSYM; s++) begin
			code_tab[s] = '0;
			code_len[s] = '0;
		end
		for (int l = 1; l <= MAXLEN; l++) begin
			for (int s = 0; s < NSYM; s++) begin
				if (len_tab[s] == 5'(l)) begin
					if (canon_count == 0) begin
						code = '0;
					end else begin
						code = (code + 1) & ((32'd1 << cur) - 1);
						code = code << (l - cur);
					end
					cur = l;
					code_tab[s] = code[15:0];
					code_len[s] = 5'(l);
					canon_order[canon_count] = 8'(s);
					canon_count++;
				end
			end
		end
	endtask

	task automatic push_bit(input logic bit_val, inout chc_pkg::rsp_t outs [$]);
		if (bit_val)
			pack_byte[7 - pack_bits] = 1'b1;
		pack_bits++;
		if (pack_bits == 8) begin
			outs = {outs, mk_rsp(chc_pkg::OK_BYTE, pack_byte, 8'd0)};
			pack_byte = '0;
			pack_bits = 0;
		end
	endtask

	task automatic huffman_step(input chc_pkg::req_t r);
		chc_pkg::rsp_t outs [$];
		logic hit_found;
		logic [7:0] hit_sym;
		logic [7:0] s;
		case (r.kind)
			chc_pkg::K_LOAD: len_tab[r.symbol] = (r.code_length > 5'(MAXLEN)) ?
				5'(MAXLEN) : r.code_length;
			chc_pkg::K_BUILD: build_canonical();
			chc_pkg::K_ENC: begin
				for (int i = int'(code_len[r.symbol]); i > 0; i--)
					push_bit(code_tab[r.symbol][i - 1], outs);
			end
			chc_pkg::K_FLUSH: begin
				if (pack_bits > 0) begin
					outs = {outs, mk_rsp(chc_pkg::OK_BYTE, pack_byte, 8'd0)};
					pack_byte = '0;
					pack_bits = 0;
				end
			end
			chc_pkg::K_START: begin
				budget_left = r.symbol_budget;
				prefix_code = '0;
				prefix_len = 0;
			end
			chc_pkg::K_DEC: begin
				for (int i = 0; i < 8 && budget_left != 0; i++) begin
					hit_found = 1'b0;
					hit_sym = '0;
					prefix_code = (prefix_code << 1) | 32'(r.data_byte[7 - i]);
					prefix_len++;
					// later entries win when codes repeat
					for (int j = 0; j < canon_count; j++) begin
						s = canon_order[j];
						if (int'(code_len[s]) == prefix_len && 32'(code_tab[s]) == prefix_code) begin
							hit_found = 1'b1;
							hit_sym = s;
						end
					end
					if (hit_found) begin
						outs = {outs, mk_rsp(chc_pkg::OK_SYM, 8'd0, hit_sym)};
						budget_left--;
						prefix_code = '0;
						prefix_len = 0;
					end else if (prefix_len > MAXLEN) begin
						outs = {outs, mk_rsp(chc_pkg::OK_ERR, 8'd0, 8'd0)};
						prefix_code = '0;
						prefix_len = 0;
					end
				end
			end
			default: ;
		endcase
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[k])
			codec_results_q = {codec_results_q, outs[k]};
	endtask

	always @(posedge clk) begin
		chc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (codec_results_q.size() == 0) begin
					$display("%0t: unexpected result: actual %p", $time, rsp);
					errors <= errors + 1;
				end else begin
					want = codec_results_q.pop_front();
					if (rsp.out_kind !== want.out_kind || rsp.out_byte !== want.out_byte ||
					    rsp.out_symbol !== want.out_symbol || rsp.last !== want.last) begin
						$display("%0t: result mismatch: expected %p actual %p", $time, want, rsp);
						errors <= errors + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				huffman_step(req);
			pending <= codec_results_q.size();
		end
	end

endmodule

/* dv/canonical_huffman_codec_top_tb.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_codec_top_tb
// Drives length loads, builds, encodes, flushes and decodes into the codec
// with random gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_top_tb;

	localparam int N_ITEMS  = 400;
	localparam int WD_LIMIT = 30000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	chc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	chc_pkg::rsp_t rsp;
	int   errors;
	int   pending;

	int   sent = 0;
	bit   no_gaps = 1'b0;
	int   long_asks = 0;
	int   long_served = 0;
	int   idle_cycles = 0;
	int   loaded_syms [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	canonical_huffman_codec_top DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	canonical_huffman_codec_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	// nothing transferred for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("canonical_huffman_codec_top_tb: FAIL");
			$finish;
		end
	end

	// response side
	initial begin
		int w;
		int quiet;
		quiet = 0;
		wait (arst_n);
		forever begin
			if (long_asks != long_served) begin
				w = LONG_HOLD;
				long_served++;
			end else begin
				if ($urandom_range(0, 30) == 0)
					quiet = $urandom_range(0, 1);
				w = quiet ? 0 : $urandom_range(0, 6);
			end
			if (w > 0) begin
				rsp_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	function automatic chc_pkg::req_t mk_req(logic [2:0] k, logic [7:0] s, logic [4:0] l,
	                                         logic [7:0] b, logic [15:0] bud);
		chc_pkg::req_t r;
		r.kind = k;
		r.symbol = s;
		r.code_length = l;
		r.data_byte = b;
		r.symbol_budget = bud;
		return r;
	endfunction

	task automatic send_item(input chc_pkg::req_t r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sent++;
	endtask

	task automatic load_len(input int s, input int l);
		send_item(mk_req(chc_pkg::K_LOAD, 8'(s), 5'(l), 8'($urandom), 16'($urandom)));
		loaded_syms = {loaded_syms, s};
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one code set: clear old lengths, load a new set, build, encode, decode
	task automatic run_sequence();
		int lens [$];
		int syms [$];
		int n, idx, l, s, dup;
		bit chain;
		while (loaded_syms.size() > 0)
			send_item(mk_req(chc_pkg::K_LOAD, 8'(loaded_syms.pop_front()), 5'd0,
			                 8'($urandom), 16'($urandom)));
		chain = ($urandom_range(0, 4) == 0);
		n = chain ? $urandom_range(2, 17) : $urandom_range(2, 8);
		lens = {lens, 0};
		repeat (n - 1) begin
			idx = chain ? lens.size() - 1 : $urandom_range(0, lens.size() - 1);
			if (lens[idx] < 16) begin
				l = lens[idx] + 1;
				lens[idx] = l;
				lens = {lens, l};
			end
		end
		// occasionally over-subscribe or leave the code incomplete
		case ($urandom_range(0, 5))
			0: lens = {lens, int'($urandom_range(1, 16))};
			1: if (lens.size() > 2) lens = lens[0:$-1];
			default: ;
		endcase
		foreach (lens[i]) begin
			do begin
				s = $urandom_range(0, 255);
				dup = 0;
				foreach (syms[j]) if (syms[j] == s) dup = 1;
			end while (dup);
			syms = {syms, s};
			load_len(s, lens[i]);
		end
		send_item(mk_req(chc_pkg::K_BUILD, 8'($urandom), 5'($urandom), 8'($urandom),
			16'($urandom)));
		repeat ($urandom_range(2, 10))
			send_item(mk_req(chc_pkg::K_ENC,
				($urandom_range(0, 7) == 0) ? 8'($urandom) :
				8'(syms[$urandom_range(0, syms.size() - 1)]),
				5'($urandom), 8'($urandom), 16'($urandom)));
		send_item(mk_req(chc_pkg::K_FLUSH, 8'($urandom), 5'($urandom), 8'($urandom),
			16'($urandom)));
		send_item(mk_req(chc_pkg::K_START, 8'($urandom), 5'($urandom), 8'($urandom),
			($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24))));
		repeat ($urandom_range(2, 8))
			send_item(mk_req(chc_pkg::K_DEC, 8'($urandom), 5'($urandom),
				($urandom_range(0, 5) == 0) ? {8{1'($urandom)}} : 8'($urandom), 16'($urandom)));
	endtask

	task automatic send_noise();
		chc_pkg::req_t r;
		repeat ($urandom_range(1, 6)) begin
			r = chc_pkg::req_t'(40'({$urandom, $urandom}));
			// builds are slow, keep them rare in noise
			if (r.kind == chc_pkg::K_BUILD && $urandom_range(0, 3) != 0)
				r.kind = chc_pkg::K_DEC;
			if (r.kind == chc_pkg::K_LOAD)
				loaded_syms = {loaded_syms, int'(r.symbol)};
			send_item(r);
		end
	endtask

	initial begin
		int seq_no;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: empty table first, then an over-subscribed set
		send_item(mk_req(chc_pkg::K_BUILD, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_ENC, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_FLUSH, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'hFF, 16'd0));
		send_item(mk_req(chc_pkg::K_START, 8'd0, 5'd0, 8'd0, 16'hFFFF));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'h00, 16'd0));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'hFF, 16'd0));
		load_len(255, 31);
		load_len(0, 1);
		load_len(1, 1);
		load_len(2, 2);
		load_len(3, 1);
		send_item(mk_req(chc_pkg::K_BUILD, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_ENC, 8'd255, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_ENC, 8'd2, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_ENC, 8'd1, 5'd0, 8'd0, 16'd0));
		// unused kinds above decode
		send_item(mk_req(3'(chc_pkg::K_DEC) + 3'd1, 8'hFF, 5'h1F, 8'hFF, 16'hFFFF));
		send_item(mk_req(3'(chc_pkg::K_DEC) + 3'd2, 8'hFF, 5'h1F, 8'hFF, 16'hFFFF));
		send_item(mk_req(chc_pkg::K_FLUSH, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_FLUSH, 8'd0, 5'd0, 8'd0, 16'd0));
		send_item(mk_req(chc_pkg::K_START, 8'd0, 5'd0, 8'd0, 16'd3));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'h55, 16'd0));
		send_item(mk_req(chc_pkg::K_START, 8'd0, 5'd0, 8'd0, 16'hFFFF));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'h00, 16'd0));
		send_item(mk_req(chc_pkg::K_DEC, 8'd0, 5'd0, 8'hA7, 16'd0));

		seq_no = 0;
		while (sent < N_ITEMS) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if (seq_no == 3)
				long_asks++;
			if (seq_no == 6)
				wait_drained();
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				run_sequence();
			seq_no++;
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("canonical_huffman_codec_top_tb: PASS");
		else
			$display("canonical_huffman_codec_top_tb: FAIL");
		$finish;
	end

endmodule
